/* design/keypad_code_alarm_controller_assert.svh */
// assertion macros for the alarm controller
`ifndef KEYPAD_CODE_ALARM_CONTROLLER_ASSERT_SVH
`define KEYPAD_CODE_ALARM_CONTROLLER_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define KAC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define KAC_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);
`else
`define KAC_ASSERT(label, prop, msg)
`define KAC_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

/* design/kac_pkg.sv */
package kac_pkg;

   localparam int CODE_DIGITS = 4;
   localparam logic [2:0] DIGITS_FULL = 3'(CODE_DIGITS);

   // key codes
   localparam logic [3:0] KEY_LAST_DIGIT = 4'd9;
   localparam logic [3:0] KEY_ENTER      = 4'd10;
   localparam logic [3:0] KEY_CANCEL     = 4'd11;

   // tones
   localparam logic [2:0] TONE_NONE    = 3'd0;
   localparam logic [2:0] TONE_OK      = 3'd1;
   localparam logic [2:0] TONE_WRONG   = 3'd2;
   localparam logic [2:0] TONE_PROMPT  = 3'd3;
   localparam logic [2:0] TONE_EXIT    = 3'd4;
   localparam logic [2:0] TONE_ENTRY   = 3'd5;
   localparam logic [2:0] TONE_MAINS   = 3'd6;

   // alarm causes
   localparam logic [1:0] CAUSE_NONE    = 2'd0;
   localparam logic [1:0] CAUSE_INSTANT = 2'd1;
   localparam logic [1:0] CAUSE_DELAYED = 2'd2;

   // register indexes
   localparam logic [1:0] CSR_EXIT_DELAY  = 2'd0;
   localparam logic [1:0] CSR_ENTRY_DELAY = 2'd1;
   localparam logic [1:0] CSR_SIREN       = 2'd2;
   localparam logic [1:0] CSR_WRONG_LIMIT = 2'd3;

   localparam logic [4:0] PHASE_LAST  = 5'd19;
   localparam logic [4:0] MAINS_PHASE = 5'd15;
   localparam logic [13:0] DEFAULT_CODE = 14'd1234;

   typedef struct packed {
      logic       key_valid;
      logic [3:0] key_code;
      logic       tick;
      logic       instant_zone;
      logic       delayed_zone;
      logic       panic_button;
      logic       mains_ok;
   } req_type;

   typedef struct packed {
      logic       armed_out;
      logic       siren_out;
      logic       arming_out;
      logic [1:0] alarm_cause;
      logic [2:0] tone;
      logic       code_changed;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  exit_delay_ticks;
      logic [7:0]  entry_delay_ticks;
      logic [15:0] siren_ticks;
      logic [7:0]  wrong_limit;
   } cfg_type;

   typedef struct packed {
      logic [2:0]       digit_count;
      logic [3:0][3:0]  digit_store;
      logic [13:0]      stored_code;
      logic             change_mode;
      logic             old_code_ok;
      logic [7:0]       wrong_count;
      logic             armed_flag;
      logic             siren_flag;
      logic             arming_flag;
      logic [7:0]       exit_count;
      logic             entry_pending;
      logic [7:0]       entry_count;
      logic [15:0]      siren_count;
      logic [4:0]       half_second_phase;
      logic [1:0]       cause_reg;
   } st_type;

   localparam st_type ST_RESET = '{
      digit_count:       3'd0,
      digit_store:       '0,
      stored_code:       DEFAULT_CODE,
      change_mode:       1'b0,
      old_code_ok:       1'b0,
      wrong_count:       8'd0,
      armed_flag:        1'b1,
      siren_flag:        1'b0,
      arming_flag:       1'b0,
      exit_count:        8'd0,
      entry_pending:     1'b0,
      entry_count:       8'd0,
      siren_count:       16'd0,
      half_second_phase: 5'd0,
      cause_reg:         CAUSE_NONE
   };

   localparam cfg_type CFG_RESET = '{
      exit_delay_ticks:  8'd30,
      entry_delay_ticks: 8'd20,
      siren_ticks:       16'd240,
      wrong_limit:       8'd4
   };

   // first tone raised in a poll wins
   function automatic logic [2:0] set_tone(input logic [2:0] cur, input logic [2:0] t);
      return (cur == TONE_NONE) ? t : cur;
   endfunction

endpackage

/* design/kac_channels.sv */
interface kac_req_if;
   logic             valid;
   logic             ready;
   kac_pkg::req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface kac_rsp_if;
   logic             valid;
   logic             ready;
   kac_pkg::rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

/* design/keypad_code_alarm_controller.sv */
// path: a taken word is held in the input register, and its result is
// registered in the result register, which drives the result port
// throughput: one word per cycle; a stalled result holds the input register,
// which takes at most one more word, and the state is updated once per word
// reset: synchronous, active high; clears both pipeline valids, loads the
// default code 1234 armed, and loads the register defaults 30, 20, 240, 4
`include "keypad_code_alarm_controller_assert.svh"

module keypad_code_alarm_controller import kac_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   kac_req_if.sink     req_ch,
   kac_rsp_if.source   rsp_ch,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   cfg_type cfg;
   st_type  st_ff, st_in;
   rsp_type result;

   logic    in_valid_ff, in_valid_in;
   req_type in_word_ff;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_word_ff;
   logic    advance;
   logic    take;

   kac_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   kac_core u_core (
      .st      (st_ff),
      .cfg     (cfg),
      .word    (in_word_ff),
      .st_next (st_in),
      .result  (result)
   );

   // a word moves on when the result register is free or being emptied
   assign advance      = in_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;
   assign take         = req_ch.valid && req_ch.ready;
   assign in_valid_in  = take || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         st_ff        <= ST_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            st_ff <= st_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_word_ff <= req_ch.payload;
      end
      if (advance) begin
         rsp_word_ff <= result;
      end
   end

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.payload = rsp_word_ff;

   `KAC_ASSERT(a_digit_count_range, st_ff.digit_count <= DIGITS_FULL, "digit count past full")
   `KAC_ASSERT(a_cause_needs_armed, st_ff.cause_reg != CAUSE_NONE |-> st_ff.armed_flag, "cause while disarmed")
   `KAC_ASSERT(a_entry_needs_armed, st_ff.entry_pending |-> st_ff.armed_flag, "entry delay while disarmed")
   `KAC_ASSERT(a_phase_range, st_ff.half_second_phase <= PHASE_LAST, "tick phase out of range")
   `KAC_ASSERT(a_held_word_stable, in_valid_ff && !advance |=> in_valid_ff && $stable(in_word_ff), "held input word lost")

endmodule

/* design/kac_csr.sv */
module kac_csr import kac_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata,
   output cfg_type     cfg
);

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_EXIT_DELAY:  cfg_in.exit_delay_ticks  = csr_wdata[7:0];
            CSR_ENTRY_DELAY: cfg_in.entry_delay_ticks = csr_wdata[7:0];
            CSR_SIREN:       cfg_in.siren_ticks       = csr_wdata;
            CSR_WRONG_LIMIT: cfg_in.wrong_limit       = csr_wdata[7:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* design/kac_core.sv */
module kac_core import kac_pkg::*; (
   input  st_type  st,
   input  cfg_type cfg,
   input  req_type word,
   output st_type  st_next,
   output rsp_type result
);

   st_type      s;
   logic [2:0]  tone;
   logic        changed;
   logic [13:0] pw;
   logic        enter_ok;

   // four digits to binary, constant multipliers only
   assign pw = 14'(st.digit_store[0]) * 14'd1000 + 14'(st.digit_store[1]) * 14'd100
             + 14'(st.digit_store[2]) * 14'd10 + 14'(st.digit_store[3]);

   assign enter_ok = word.key_valid && word.key_code == KEY_ENTER
                  && st.digit_count == DIGITS_FULL;

   always_comb begin
      s       = st;
      tone    = TONE_NONE;
      changed = 1'b0;

      // keypad
      if (word.key_valid) begin
         if (word.key_code == KEY_CANCEL) begin
            s.digit_count = 3'd0;
         end else if (word.key_code <= KEY_LAST_DIGIT) begin
            if (st.digit_count < DIGITS_FULL) begin
               s.digit_store[st.digit_count[1:0]] = word.key_code;
               s.digit_count = st.digit_count + 3'd1;
            end
         end
      end

      // code commit
      if (enter_ok) begin
         s.digit_count = 3'd0;
         if (pw == st.stored_code && !st.change_mode) begin
            s.wrong_count = 8'd0;
            tone = set_tone(tone, TONE_OK);
            if (st.armed_flag || st.siren_flag || st.arming_flag) begin
               s.siren_flag    = 1'b0;
               s.armed_flag    = 1'b0;
               s.arming_flag   = 1'b0;
               s.entry_pending = 1'b0;
               s.cause_reg     = CAUSE_NONE;
            end else begin
               s.arming_flag = 1'b1;
               s.exit_count  = 8'd0;
            end
         end else if (pw == 14'd0 || st.change_mode) begin
            s.change_mode = 1'b1;
            if (pw == st.stored_code || st.old_code_ok) begin
               if (pw != 14'd0 && st.old_code_ok) begin
                  s.stored_code = pw;
                  changed       = 1'b1;
                  tone          = set_tone(tone, TONE_OK);
                  s.change_mode = 1'b0;
                  s.old_code_ok = 1'b0;
               end else begin
                  s.old_code_ok = 1'b1;
                  tone          = set_tone(tone, TONE_PROMPT);
               end
            end else if (pw != 14'd0) begin
               tone          = set_tone(tone, TONE_WRONG);
               s.change_mode = 1'b0;
            end else begin
               tone = set_tone(tone, TONE_PROMPT);
            end
         end else begin
            if (st.wrong_count != 8'hFF) begin
               s.wrong_count = st.wrong_count + 8'd1;
            end
            tone = set_tone(tone, TONE_WRONG);
            if (s.wrong_count >= cfg.wrong_limit && st.armed_flag) begin
               s.siren_flag  = 1'b1;
               s.siren_count = 16'd0;
               s.wrong_count = 8'd0;
            end
         end
      end

      // delayed zone opens the entry window
      if (s.armed_flag && !s.siren_flag && word.delayed_zone && !s.entry_pending) begin
         s.entry_pending = 1'b1;
         s.entry_count   = 8'd0;
         tone            = set_tone(tone, TONE_ENTRY);
      end

      if (word.tick) begin
         s.half_second_phase = (s.half_second_phase == PHASE_LAST) ? 5'd0
                             : s.half_second_phase + 5'd1;
         if (s.arming_flag) begin
            if (s.exit_count != 8'hFF) begin
               s.exit_count = s.exit_count + 8'd1;
            end
            if (s.exit_count >= cfg.exit_delay_ticks) begin
               s.arming_flag = 1'b0;
               s.armed_flag  = 1'b1;
               s.siren_flag  = 1'b0;
            end else begin
               tone = set_tone(tone, TONE_EXIT);
            end
         end
         if (s.entry_pending) begin
            if (s.entry_count != 8'hFF) begin
               s.entry_count = s.entry_count + 8'd1;
            end
            if (s.entry_count >= cfg.entry_delay_ticks) begin
               s.entry_pending = 1'b0;
               if (s.armed_flag && !s.siren_flag) begin
                  s.siren_flag  = 1'b1;
                  s.siren_count = 16'd0;
                  s.cause_reg   = CAUSE_DELAYED;
               end
            end else begin
               tone = set_tone(tone, TONE_ENTRY);
            end
         end
         if (s.siren_flag) begin
            if (s.siren_count != 16'hFFFF) begin
               s.siren_count = s.siren_count + 16'd1;
            end
            if (s.siren_count >= cfg.siren_ticks) begin
               s.siren_flag = 1'b0;
            end
         end
         if (!word.mains_ok && s.half_second_phase == MAINS_PHASE) begin
            tone = set_tone(tone, TONE_MAINS);
         end
      end

      // instant zone while armed, panic while disarmed
      if (s.armed_flag && !s.siren_flag) begin
         if (word.instant_zone) begin
            s.siren_flag  = 1'b1;
            s.siren_count = 16'd0;
            s.cause_reg   = CAUSE_INSTANT;
         end
      end else if (!s.armed_flag && !s.siren_flag) begin
         if (word.panic_button) begin
            s.siren_flag  = 1'b1;
            s.siren_count = 16'd0;
         end
      end

      if (!s.armed_flag) begin
         s.cause_reg = CAUSE_NONE;
      end
   end

   assign st_next = s;

   assign result.armed_out    = s.armed_flag;
   assign result.siren_out    = s.siren_flag;
   assign result.arming_out   = s.arming_flag;
   assign result.alarm_cause  = s.cause_reg;
   assign result.tone         = tone;
   assign result.code_changed = changed;

endmodule
